/* hdl/sbp_pkg.sv */
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared widths, codes and constants of the sample buffer player.
// ----------------------------------------------------------------------------
package sbp_pkg;

  // Field widths of the input and result words
  localparam int CMD_W    = 1;
  localparam int ADDR_W   = 16;
  localparam int VALUE_W  = 24;
  localparam int RATE_W   = 20;
  localparam int START_W  = 16;
  localparam int OUT_W    = 24;

  // Configuration registers
  localparam int LENGTH_W     = 17;
  localparam int RSCALE_W     = 18;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_SCALE = 1'b1;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 17'd65536;
  localparam logic [RSCALE_W-1:0] RSCALE_RESET = 18'd65536;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b1;

  // Fixed point
  localparam int FRAC_W     = 16;
  localparam int ROUND_HALF = 32768;
  localparam int MIN_LENGTH = 64;
  localparam int WORD_W     = 32;

endpackage

/* hdl/sbp_sample_mem.sv */
// ----------------------------------------------------------------------------
// sbp_sample_mem
// Sample store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module sbp_sample_mem #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 24,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* hdl/sample_buffer_player_top.sv */
// ----------------------------------------------------------------------------
// sample_buffer_player_top
// Mono sample player with linear interpolation between adjacent frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per command. A load
//   word writes sample_value to frame sample_addr and produces no result.
//   A tick word produces one result word on the output channel (out_valid /
//   out_stall) holding the interpolated sample_out. A tick passes through
//   the steps accept (phase select, offset and increment multiplies),
//   position (wrap, address generation, phase update, both sample reads
//   issued on the two memory read ports), read (difference times fraction),
//   finish (round and add into the output register). out_valid is set
//   from the finish step. A new tick is not accepted until the previous one
//   has left finish; loads run at one per cycle while no tick is running.
//   The output register holds one result; a new item is accepted while it
//   waits. If the receiver stalls with the register full, the next tick
//   holds in its finish step, and in_stall stays high until it drains.
//   Configuration (length, rate_scale) is written through cfg_wr_en, cfg_index
//   and cfg_data; the user must write it only while the block is idle (not enforced).
//   Reset clears the phase to zero, sets length to 65536 and rate_scale to
//   1.0, and empties the output register. The sample memory is not cleared.
// ----------------------------------------------------------------------------
module sample_buffer_player_top
  import sbp_pkg::*;
#(
  parameter int MAX_FRAMES  = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          command,
  input  logic [ADDR_W-1:0]         sample_addr,
  input  logic signed [VALUE_W-1:0] sample_value,
  input  logic [RATE_W-1:0]         rate,
  input  logic                      trigger,
  input  logic [START_W-1:0]        start_offset,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   sample_out,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW     = $clog2(MAX_FRAMES);
  localparam int LEN_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
  localparam int AC_W   = (LEN_W > ADDR_W) ? LEN_W : ADDR_W;
  localparam int PH_W   = LEN_W + FRAC_W;
  localparam int INC_W  = RATE_W + RSCALE_W;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PW     = DIFF_W + FRAC_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POS  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]            state;
  logic [LENGTH_W-1:0]   length;
  logic [RSCALE_W-1:0]   rate_scale;
  logic [PH_W-1:0]       play_phase;

  // tick pipeline registers
  logic [PH_W-1:0]       ph0;
  logic [PH_W-1:0]       offset;
  logic [INC_W-1:0]      inc_prod;
  logic [FRAC_W-1:0]     frac;
  logic [SAMPLE_BITS-1:0] a_hold;
  logic signed [PW-1:0]  prod;

  // ---------------------------------------------------------------------
  // Effective length and span (length clamped to 64..MAX_FRAMES)
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] len_cmp;
  logic [LEN_W-1:0] len_eff;
  logic [PH_W-1:0]  span;

  always_comb begin
    len_cmp = CMP_W'(length);
    priority if (len_cmp < CMP_W'(MIN_LENGTH)) begin
      len_eff = LEN_W'(MIN_LENGTH);
    end else if (len_cmp > CMP_W'(MAX_FRAMES)) begin
      len_eff = LEN_W'(MAX_FRAMES);
    end else begin
      len_eff = len_cmp[LEN_W-1:0];
    end
  end

  assign span = {len_eff, {FRAC_W{1'b0}}};

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic in_take;
  logic tick_take;
  logic load_take;
  logic out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign tick_take = in_take && (command == CMD_TICK);
  assign load_take = in_take && (command == CMD_LOAD);
  assign out_free  = !out_valid || !out_stall;

  // ---------------------------------------------------------------------
  // Load path: drop addresses beyond the memory, zero-extend the value
  // ---------------------------------------------------------------------
  logic [AC_W-1:0]        addr_ext;
  logic [WORD_W-1:0]      value_ext;
  logic                   addr_ok;

  assign addr_ext  = AC_W'(sample_addr);
  assign addr_ok   = addr_ext < AC_W'(MAX_FRAMES);
  assign value_ext = {{(WORD_W - VALUE_W){1'b0}}, sample_value};

  // ---------------------------------------------------------------------
  // Accept step: phase select and the two multiplies
  // ---------------------------------------------------------------------
  logic [PH_W-1:0] ph_sel;
  logic [PH_W-1:0] offset_next;

  assign ph_sel      = (trigger || (play_phase >= span)) ? '0 : play_phase;
  assign offset_next = {{LEN_W{1'b0}}, start_offset} * {{FRAC_W{1'b0}}, len_eff};

  // ---------------------------------------------------------------------
  // Position step: wrap, addresses, phase advance
  // ---------------------------------------------------------------------
  logic [PH_W:0]   pos_sum;
  logic [PH_W-1:0] pos;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] idx_inc;
  logic [LEN_W-1:0] idx_nxt;
  logic [PH_W:0]   ph_sum;
  logic [PH_W-1:0] play_phase_next;

  always_comb begin
    pos_sum = {1'b0, ph0} + {1'b0, offset};
    if (pos_sum >= {1'b0, span}) begin
      pos = PH_W'(pos_sum - {1'b0, span});
    end else begin
      pos = pos_sum[PH_W-1:0];
    end
    idx     = pos[PH_W-1:FRAC_W];
    idx_inc = idx + LEN_W'(1);
    idx_nxt = (idx_inc >= len_eff) ? '0 : idx_inc;

    ph_sum = {1'b0, ph0} + (PH_W + 1)'(inc_prod[INC_W-1:FRAC_W]);
    if (ph_sum >= {1'b0, span}) begin
      play_phase_next = PH_W'(ph_sum - {1'b0, span});
    end else begin
      play_phase_next = ph_sum[PH_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sample memory
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] rd_a;
  logic [SAMPLE_BITS-1:0] rd_b;

  sbp_sample_mem #(
    .DEPTH  (MAX_FRAMES),
    .DATA_W (SAMPLE_BITS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (load_take && addr_ok),
    .wr_addr   (addr_ext[AW-1:0]),
    .wr_data   (value_ext[SAMPLE_BITS-1:0]),
    .rd_en     (state == S_POS),
    .rd_addr_a (idx[AW-1:0]),
    .rd_addr_b (idx_nxt[AW-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // ---------------------------------------------------------------------
  // Read step: (b - a) * frac; finish step: a + round(product / 2^16)
  // ---------------------------------------------------------------------
  logic signed [DIFF_W-1:0]     diff;
  logic signed [FRAC_W:0]       frac_s;
  logic signed [PW-1:0]         prod_next;
  logic signed [PW-1:0]         rnd;
  logic [SUM_W-1:0]             res_sum;
  logic signed [SAMPLE_BITS-1:0] res_s;
  logic signed [WORD_W-1:0]     res_word;

  assign diff      = $signed({rd_b[SAMPLE_BITS-1], rd_b}) -
                     $signed({rd_a[SAMPLE_BITS-1], rd_a});
  assign frac_s    = $signed({1'b0, frac});
  assign prod_next = diff * frac_s;

  assign rnd      = prod + PW'(ROUND_HALF);
  assign res_sum  = {{2{a_hold[SAMPLE_BITS-1]}}, a_hold} + rnd[PW-1:FRAC_W];
  assign res_s    = res_sum[SAMPLE_BITS-1:0];
  assign res_word = WORD_W'(res_s);

  // ---------------------------------------------------------------------
  // Sequencer and registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      play_phase <= '0;
      length     <= LENGTH_RESET;
      rate_scale <= RSCALE_RESET;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_LENGTH:     length     <= cfg_data[LENGTH_W-1:0];
          REG_RATE_SCALE: rate_scale <= cfg_data[RSCALE_W-1:0];
          default: ;
        endcase
      end

      // when the register is free, load it from the finish step or drain it
      if (out_free) begin
        out_valid <= (state == S_FIN);
      end

      unique case (state)
        S_IDLE: begin
          if (tick_take) begin
            state <= S_POS;
          end
        end
        S_POS: begin
          play_phase <= play_phase_next;
          state      <= S_RD;
        end
        S_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register has room
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick_take) begin
      ph0      <= ph_sel;
      offset   <= offset_next;
      inc_prod <= rate * rate_scale;
    end
    if (state == S_POS) begin
      frac <= pos[FRAC_W-1:0];
    end
    if (state == S_RD) begin
      a_hold <= rd_a;
      prod   <= prod_next;
    end
    if ((state == S_FIN) && out_free) begin
      sample_out <= res_word[OUT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tick_seq: assert property (@(posedge clk) disable iff (rst)
    tick_take |=> (state == S_POS) ##1 (state == S_RD) ##1 (state == S_FIN))
    else $error("tick did not step through position, read and finish");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result word appeared outside the finish step");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_valid && out_stall |=> (state == S_FIN))
    else $error("finish step overwrote a stalled result");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_POS) |-> (pos < span) && (idx_nxt < len_eff))
    else $error("read position outside the sample span");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_POS) |-> (play_phase_next < span))
    else $error("advanced phase not wrapped");

endmodule
